// File: hw/rtl/swa_pkg.sv
// Shared constants, types and codes of the sliding window aggregate.
package swa_pkg;

   localparam int WINDOW_MAX = 256;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
   localparam int SAMPLE_W   = 32;
   localparam int AGG_W      = 40;
   localparam int WL_W       = 9;
   localparam int SUM_W      = SAMPLE_W + CNT_W;
   localparam int SAT_W      = (SUM_W > AGG_W) ? SUM_W : AGG_W;
   localparam int NW         = (CNT_W > WL_W) ? CNT_W : WL_W;

   localparam logic signed [AGG_W-1:0] AGG_MAX = {1'b0, {(AGG_W-1){1'b1}}};
   localparam logic signed [AGG_W-1:0] AGG_MIN = {1'b1, {(AGG_W-1){1'b0}}};

   typedef enum logic [1:0] {
      MODE_AVG = 2'd0,
      MODE_MIN = 2'd1,
      MODE_MAX = 2'd2,
      MODE_SUM = 2'd3
   } mode_type;

   typedef enum logic {
      REG_WINDOW_LENGTH = 1'b0,
      REG_MODE          = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DIV,
      ST_DONE
   } fsm_state_type;

endpackage

// File: hw/rtl/swa_ram.sv
// Generic synchronous RAM with one write port, one read port and a registered read.
module swa_ram #(
   parameter int ADDR_W = 8,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/swa_div.sv
// Iterative restoring divider for unsigned magnitudes, one quotient bit per cycle.
module swa_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [swa_pkg::SUM_W-1:0] dividend,
   input  logic [swa_pkg::CNT_W-1:0] divisor,
   output logic                      done,
   output logic [swa_pkg::SUM_W-1:0] quotient
);
   import swa_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W:0]    rem_sh;
   logic [CNT_W:0]    diff;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(SUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[CNT_W]) begin
            rem_in = diff[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[CNT_W-1:0];
            quo_in = {quo_ff[SUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      step_ff <= step_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hw/rtl/sliding_window_aggregate.sv
// Top level of the sliding window aggregate: scan sequencer, accumulators and output register.
//
//  Channel   Ports                          Direction
//  req       req_valid req_ready req_sample  in
//  rsp       rsp_valid rsp_ready rsp_aggregate out
//  csr       csr_we csr_index csr_wdata     in
//
// One beat passes through IDLE, SCAN over the k stored samples used (at most 256) and DONE,
// which waits for the output register to be free; average mode with k nonzero adds DIV,
// where the divider produces one quotient bit per cycle.
// The scan reads the history memory one entry per cycle through its read port.
// Reset clears the write pointer and fill count; the history memory needs no clearing.
// A new beat is taken while the previous result waits in the output register.
module sliding_window_aggregate (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [swa_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [swa_pkg::AGG_W-1:0]    rsp_aggregate,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [swa_pkg::WL_W-1:0]            csr_wdata
);
   import swa_pkg::*;

   fsm_state_type              state_ff, state_in;
   logic [WL_W-1:0]            win_len_ff;
   mode_type                   mode_ff;
   logic [SAMPLE_W-1:0]        sample_ff, sample_in;
   logic [IDX_W-1:0]           wp_ff, wp_in;
   logic [IDX_W-1:0]           rp_ff, rp_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [CNT_W-1:0]           k_ff, k_in;
   logic [CNT_W-1:0]           issue_ff, issue_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic                       any_ff, any_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [SAMPLE_W-1:0] lo_ff, lo_in;
   logic signed [SAMPLE_W-1:0] hi_ff, hi_in;
   logic signed [AGG_W-1:0]    res_ff, res_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                       accept;
   logic                       rd_en;
   logic                       wr_en;
   logic                       out_free;
   logic                       scan_end;
   logic                       div_start;
   logic                       div_done;
   logic [SUM_W-1:0]           div_quo;
   logic [SUM_W-1:0]           sum_mag;
   logic signed [SAMPLE_W-1:0] rd_data;
   logic [SAMPLE_W-1:0]        rd_raw;
   logic [NW-1:0]              n_cap;
   logic [NW-1:0]              k_calc;
   logic signed [SAT_W-1:0]    sum_ext;
   logic signed [AGG_W-1:0]    sum_sat;
   logic signed [SUM_W-1:0]    rd_ext;
   logic signed [SUM_W-1:0]    quo_signed;

   swa_ram #(
      .ADDR_W (IDX_W),
      .DATA_W (SAMPLE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (sample_ff),
      .rd_en   (rd_en),
      .rd_addr (rp_ff),
      .rd_data (rd_raw)
   );

   swa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_mag),
      .divisor  (k_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rd_data  = signed'(rd_raw);
   assign rd_ext   = SUM_W'(rd_data);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scan_end = (issue_ff == k_ff) && !rd_vld_ff;
   assign sum_mag  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               if (mode_ff == MODE_AVG && k_ff != '0) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_SCAN: begin
            rd_en     = (issue_ff != k_ff);
            div_start = scan_end && (mode_ff == MODE_AVG) && (k_ff != '0);
         end
         ST_DIV:  ;
         ST_DONE: wr_en = out_free;
         default: ;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_comb begin
      n_cap  = (NW'(win_len_ff) > NW'(WINDOW_MAX)) ? NW'(WINDOW_MAX) : NW'(win_len_ff);
      k_calc = (n_cap < NW'(fill_ff)) ? n_cap : NW'(fill_ff);
   end

   always_comb begin
      sum_ext    = SAT_W'(sum_ff);
      quo_signed = sum_ff[SUM_W-1] ? -signed'(div_quo) : signed'(div_quo);
      if (sum_ext > SAT_W'(AGG_MAX)) begin
         sum_sat = AGG_MAX;
      end else if (sum_ext < SAT_W'(AGG_MIN)) begin
         sum_sat = AGG_MIN;
      end else begin
         sum_sat = AGG_W'(sum_ff);
      end
   end

   always_comb begin
      sample_in    = sample_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      issue_in     = issue_ff;
      rd_vld_in    = rd_en;
      any_in       = any_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (accept) begin
         sample_in = req_sample;
         rp_in     = (wp_ff == '0) ? IDX_W'(WINDOW_MAX - 1) : wp_ff - IDX_W'(1);
         k_in      = CNT_W'(k_calc);
         issue_in  = '0;
         any_in    = 1'b0;
         sum_in    = '0;
         lo_in     = '0;
         hi_in     = '0;
      end

      if (rd_en) begin
         issue_in = issue_ff + CNT_W'(1);
         rp_in    = (rp_ff == '0) ? IDX_W'(WINDOW_MAX - 1) : rp_ff - IDX_W'(1);
      end

      if (rd_vld_ff) begin
         any_in = 1'b1;
         sum_in = sum_ff + rd_ext;
         if (!any_ff || rd_data < lo_ff) begin
            lo_in = rd_data;
         end
         if (!any_ff || rd_data > hi_ff) begin
            hi_in = rd_data;
         end
      end

      if (wr_en) begin
         rsp_valid_in = 1'b1;
         wp_in        = (wp_ff == IDX_W'(WINDOW_MAX - 1)) ? '0 : wp_ff + IDX_W'(1);
         if (fill_ff != CNT_W'(WINDOW_MAX)) begin
            fill_in = fill_ff + CNT_W'(1);
         end
         if (k_ff == '0) begin
            res_in = '0;
         end else begin
            unique case (mode_ff)
               MODE_AVG: res_in = AGG_W'(quo_signed);
               MODE_MIN: res_in = AGG_W'(lo_ff);
               MODE_MAX: res_in = AGG_W'(hi_ff);
               MODE_SUM: res_in = sum_sat;
               default:  res_in = sum_sat;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         win_len_ff   <= WL_W'(1);
         mode_ff      <= MODE_SUM;
         wp_ff        <= '0;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (reg_index_type'(csr_index))
               REG_WINDOW_LENGTH: win_len_ff <= csr_wdata;
               REG_MODE:          mode_ff    <= mode_type'(csr_wdata[1:0]);
               default:           ;
            endcase
         end
      end
      sample_ff <= sample_in;
      rp_ff     <= rp_in;
      k_ff      <= k_in;
      issue_ff  <= issue_in;
      any_ff    <= any_in;
      sum_ff    <= sum_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      res_ff    <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_aggregate = res_ff;

endmodule

// File: test/testbench.sv
// Self-checking testbench for the sliding window aggregate, with its own window predictor.
module testbench;
   import swa_pkg::*;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [AGG_W-1:0]    rsp_aggregate;
   logic                       csr_we = 1'b0;
   logic                       csr_index = 1'b0;
   logic [WL_W-1:0]            csr_wdata = '0;

   logic [SAMPLE_W-1:0]        sample_queue [$];
   logic signed [AGG_W-1:0]    expected_aggregates [$];
   logic signed [SAMPLE_W-1:0] past_samples [WINDOW_MAX];
   logic [IDX_W-1:0]           write_slot = '0;
   int                         stored_count = 0;
   logic [WL_W-1:0]            window_setting = WL_W'(1);
   mode_type                   mode_setting = MODE_SUM;

   int                         error_count = 0;
   int                         gap_left = 0;
   int                         burst_left = 1;
   int                         stall_style = 0;
   int                         style_left = 0;
   int                         ready_phase = 0;
   logic                       hold_receiver = 1'b0;
   logic                       pressure_on = 1'b0;
   logic signed [AGG_W-1:0]    expected_head;
   logic                       ready_pick;

   sliding_window_aggregate dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample    (req_sample),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_aggregate (rsp_aggregate),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch: %s", what);
   endtask

   task automatic predict_window_aggregate(input logic signed [SAMPLE_W-1:0] sample);
      int               span;
      int               used;
      longint           total;
      longint           lowest;
      longint           highest;
      longint           value;
      longint           outcome;
      logic [IDX_W-1:0] slot;
      span = (window_setting > WINDOW_MAX) ? WINDOW_MAX : int'(window_setting);
      used = (span < stored_count) ? span : stored_count;
      total = 0;
      lowest = 0;
      highest = 0;
      outcome = 0;
      for (int i = 0; i < used; i++) begin
         slot = IDX_W'(write_slot - 1 - i);
         value = past_samples[slot];
         total += value;
         if (i == 0 || value < lowest) begin
            lowest = value;
         end
         if (i == 0 || value > highest) begin
            highest = value;
         end
      end
      if (used > 0) begin
         case (mode_setting)
            MODE_AVG: begin
               outcome = total / used;
            end
            MODE_MIN: begin
               outcome = lowest;
            end
            MODE_MAX: begin
               outcome = highest;
            end
            default: begin
               outcome = total;
               if (outcome > AGG_MAX) begin
                  outcome = AGG_MAX;
               end
               if (outcome < AGG_MIN) begin
                  outcome = AGG_MIN;
               end
            end
         endcase
      end
      expected_aggregates.push_back(AGG_W'(outcome));
      past_samples[write_slot] = sample;
      write_slot = write_slot + 1'b1;
      if (stored_count < WINDOW_MAX) begin
         stored_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample <= '0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         if (req_valid && req_ready) begin
            predict_window_aggregate(req_sample);
         end
         if (!req_valid || req_ready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_sample <= sample_queue.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_aggregates.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, aggregate %0d", rsp_aggregate));
            end else begin
               expected_head = expected_aggregates.pop_front();
               if (rsp_aggregate !== expected_head) begin
                  report_mismatch($sformatf("aggregate %0d, expected %0d",
                                            rsp_aggregate, expected_head));
               end
            end
         end
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 3);
            style_left = $urandom_range(10, 120);
         end else begin
            style_left--;
         end
         ready_phase = (ready_phase + 1) % 5;
         case (stall_style)
            0: begin
               ready_pick = 1'b1;
            end
            1: begin
               ready_pick = 1'($urandom_range(0, 1));
            end
            2: begin
               ready_pick = ($urandom_range(0, 3) == 0);
            end
            default: begin
               ready_pick = (ready_phase < 2);
            end
         endcase
         rsp_ready <= ready_pick && !hold_receiver;
      end
   end

   initial begin
      wait (pressure_on);
      @(posedge clock);
      hold_receiver <= 1'b1;
      repeat (400) @(posedge clock);
      hold_receiver <= 1'b0;
   end

   initial begin
      #16000000;
      $display("[sliding_window_aggregate] ERROR");
      $finish;
   end

   task automatic write_register(input reg_index_type index, input logic [WL_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == REG_WINDOW_LENGTH) begin
         window_setting = value;
      end else begin
         mode_setting = mode_type'(value[1:0]);
      end
   endtask

   task automatic configure(input logic [WL_W-1:0] window, input mode_type mode_code);
      write_register(REG_WINDOW_LENGTH, window);
      write_register(REG_MODE, {(WL_W-2)'($urandom_range(0, 127)), mode_code});
      @(negedge clock);
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (sample_queue.size() != 0 || req_valid || expected_aggregates.size() != 0);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 9))
         0: begin
            return 32'h7FFF_FFFF;
         end
         1: begin
            return 32'h8000_0000;
         end
         2, 3: begin
            return 32'($urandom_range(0, 31)) - 32'd16;
         end
         default: begin
            return $urandom();
         end
      endcase
   endfunction

   function automatic logic [WL_W-1:0] random_window();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            return WL_W'($urandom_range(1, 8));
         end
         4, 5: begin
            return WL_W'($urandom_range(9, 64));
         end
         6: begin
            return WL_W'(0);
         end
         7: begin
            return WL_W'(WINDOW_MAX);
         end
         8: begin
            return WL_W'($urandom_range(WINDOW_MAX + 1, (1 << WL_W) - 1));
         end
         default: begin
            return WL_W'($urandom_range(65, WINDOW_MAX - 1));
         end
      endcase
   endfunction

   initial begin
      int planned;
      int count;
      planned = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sample_queue = {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0,
                      32'h5555_5555, 32'hAAAA_AAAA, 32'h1};
      wait_idle();
      configure(WL_W'(4), MODE_AVG);
      sample_queue = {32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFD, 32'h7, 32'hFFFF_FFFE};
      wait_idle();
      configure(WL_W'(0), MODE_MIN);
      sample_queue = {32'h8000_0000, 32'h7FFF_FFFF};
      wait_idle();
      configure(WL_W'(511), MODE_MAX);
      sample_queue = {32'h8000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF};
      wait_idle();
      configure(WL_W'(WINDOW_MAX), MODE_SUM);
      sample_queue = {32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678};
      wait_idle();
      planned = 20;

      configure(WL_W'(3), MODE_SUM);
      for (int i = 0; i < 60; i++) begin
         sample_queue.push_back(random_sample());
      end
      pressure_on = 1'b1;
      planned += 60;
      wait_idle();

      while (planned < 1650) begin
         configure(random_window(), mode_type'($urandom_range(0, 3)));
         count = $urandom_range(20, 80);
         for (int i = 0; i < count; i++) begin
            sample_queue.push_back(random_sample());
         end
         planned += count;
         wait_idle();
      end

      repeat (320) @(posedge clock);
      if (error_count == 0) begin
         $display("[sliding_window_aggregate] OK");
      end else begin
         $display("[sliding_window_aggregate] ERROR");
      end
      $finish;
   end

endmodule

// File: sliding_window_aggregate.f
hw/rtl/swa_pkg.sv
hw/rtl/swa_ram.sv
hw/rtl/swa_div.sv
hw/rtl/sliding_window_aggregate.sv
test/testbench.sv
